[src/rtcw_pkg.sv]
package rtcw_pkg;

	localparam logic [2:0] OP_WRITE_BYTE  = 3'd0;
	localparam logic [2:0] OP_READ_BYTE   = 3'd1;
	localparam logic [2:0] OP_BURST_READ  = 3'd2;
	localparam logic [2:0] OP_BURST_WRITE = 3'd3;
	localparam logic [2:0] OP_TICK        = 3'd4;

	localparam logic [7:0] CMD_BURST_READ  = 8'hBF;
	localparam logic [7:0] CMD_BURST_WRITE = 8'hBE;
	localparam logic [7:0] WEEKDAY_VALUE   = 8'h01;
	localparam logic [7:0] PROTECT_VALUE   = 8'h00;

	// field slots: clock fields first, then the fixed bytes of a burst
	localparam logic [3:0] SLOT_DAY     = 4'd0;
	localparam logic [3:0] SLOT_MONTH   = 4'd1;
	localparam logic [3:0] SLOT_YEAR    = 4'd2;
	localparam logic [3:0] SLOT_HOUR    = 4'd3;
	localparam logic [3:0] SLOT_MINUTE  = 4'd4;
	localparam logic [3:0] SLOT_SECOND  = 4'd5;
	localparam logic [3:0] SLOT_WEEKDAY = 4'd6;
	localparam logic [3:0] SLOT_PROTECT = 4'd7;
	localparam logic [3:0] SLOT_COMMAND = 4'd8;
	localparam int         NUM_FIELDS   = 6;

	typedef logic [NUM_FIELDS-1:0][7:0] fields_t;

	typedef struct packed {
		logic [2:0] operation;
		logic [7:0] address;
		logic [7:0] write_data;
		fields_t    set_fields;
		logic       io_in;
	} item_t;

	typedef struct packed {
		logic       chip_enable;
		logic       serial_clock;
		logic       io_out;
		logic       io_drive;
		logic       done_res;
		logic [7:0] read_byte;
		fields_t    fields;
	} result_t;

	function automatic logic [3:0] burst_slot(input logic [3:0] k);
		logic [3:0] s;
		case (k)
			4'd0:    s = SLOT_COMMAND;
			4'd1:    s = SLOT_SECOND;
			4'd2:    s = SLOT_MINUTE;
			4'd3:    s = SLOT_HOUR;
			4'd4:    s = SLOT_DAY;
			4'd5:    s = SLOT_MONTH;
			4'd6:    s = SLOT_WEEKDAY;
			4'd7:    s = SLOT_YEAR;
			default: s = SLOT_PROTECT;
		endcase
		return s;
	endfunction

	function automatic logic [3:0] total_bytes(input logic [1:0] op);
		logic [3:0] n;
		case (op)
			OP_WRITE_BYTE[1:0]: n = 4'd2;
			OP_READ_BYTE[1:0]:  n = 4'd2;
			OP_BURST_READ[1:0]: n = 4'd8;
			default:            n = 4'd9;
		endcase
		return n;
	endfunction

endpackage

[src/rtcw_engine.sv]
module rtcw_engine (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            adv,
	input  rtcw_pkg::item_t item,
	output rtcw_pkg::result_t res
);
	import rtcw_pkg::*;

	logic       busy_q, busy_d;
	logic [1:0] active_op_q, active_op_d;
	logic       half_phase_q, half_phase_d;
	logic [2:0] bit_index_q, bit_index_d;
	logic [3:0] byte_index_q, byte_index_d;
	logic       enable_q, enable_d;
	logic       clock_q, clock_d;
	logic       level_q, level_d;
	logic       drive_q, drive_d;
	logic [7:0] shift_q, shift_d;
	logic [7:0] command_q, command_d;
	logic [7:0] data_q, data_d;
	fields_t    fields_q, fields_d;
	logic       done_d;
	logic       wr;
	logic [3:0] slot;

	function automatic logic is_write(input logic [3:0] k, input logic [1:0] op);
		return (k == 4'd0) || (op == OP_WRITE_BYTE[1:0]) || (op == OP_BURST_WRITE[1:0]);
	endfunction

	function automatic logic [7:0] load_byte(input logic [3:0] k, input logic [1:0] op,
			input logic [7:0] cmd, input logic [7:0] dat, input fields_t f);
		logic [3:0] s;
		logic [7:0] v;
		s = burst_slot(k);
		if (k >= total_bytes(op) || !is_write(k, op))
			v = 8'h00;
		else if (k == 4'd0)
			v = cmd;
		else if (op == OP_WRITE_BYTE[1:0])
			v = dat;
		else if (s == SLOT_WEEKDAY)
			v = WEEKDAY_VALUE;
		else if (s == SLOT_PROTECT || s == SLOT_COMMAND)
			v = PROTECT_VALUE;
		else
			v = f[s[2:0]];
		return v;
	endfunction

	always_comb begin
		busy_d       = busy_q;
		active_op_d  = active_op_q;
		half_phase_d = half_phase_q;
		bit_index_d  = bit_index_q;
		byte_index_d = byte_index_q;
		enable_d     = enable_q;
		clock_d      = clock_q;
		level_d      = level_q;
		drive_d      = drive_q;
		shift_d      = shift_q;
		command_d    = command_q;
		data_d       = data_q;
		fields_d     = fields_q;
		done_d       = 1'b0;
		wr           = is_write(byte_index_q, active_op_q);
		slot         = burst_slot(byte_index_q);

		if (item.operation <= OP_BURST_WRITE) begin
			if (!busy_q) begin
				busy_d       = 1'b1;
				active_op_d  = item.operation[1:0];
				half_phase_d = 1'b0;
				bit_index_d  = '0;
				byte_index_d = '0;
				case (item.operation)
					OP_BURST_READ:  command_d = CMD_BURST_READ;
					OP_BURST_WRITE: command_d = CMD_BURST_WRITE;
					default:        command_d = item.address;
				endcase
				if (item.operation == OP_WRITE_BYTE)
					data_d = item.write_data;
				if (item.operation == OP_BURST_WRITE)
					fields_d = item.set_fields;
				shift_d  = command_d;
				enable_d = 1'b1;
				clock_d  = 1'b0;
				level_d  = 1'b0;
				drive_d  = 1'b0;
			end
		end else if (item.operation == OP_TICK && busy_q) begin
			if (byte_index_q >= total_bytes(active_op_q)) begin
				busy_d       = 1'b0;
				enable_d     = 1'b0;
				clock_d      = 1'b0;
				level_d      = 1'b0;
				drive_d      = 1'b0;
				half_phase_d = 1'b0;
				done_d       = 1'b1;
			end else if (!half_phase_q) begin
				// clock low: put the next bit on the line, or release it
				clock_d      = 1'b0;
				drive_d      = wr;
				level_d      = wr & shift_q[bit_index_q];
				half_phase_d = 1'b1;
			end else begin
				if (!wr)
					shift_d = shift_q | (8'(item.io_in) << bit_index_q);
				clock_d      = 1'b1;
				half_phase_d = 1'b0;
				if (bit_index_q == 3'd7) begin
					bit_index_d = '0;
					if (!wr) begin
						if (active_op_q == OP_READ_BYTE[1:0])
							data_d = shift_d;
						else if (active_op_q == OP_BURST_READ[1:0] &&
								byte_index_q != 4'd0 && slot < SLOT_WEEKDAY)
							fields_d[slot[2:0]] = shift_d;
					end
					byte_index_d = byte_index_q + 4'd1;
					shift_d = load_byte(byte_index_d, active_op_q, command_q, data_q, fields_q);
				end else begin
					bit_index_d = bit_index_q + 3'd1;
				end
			end
		end

		res.chip_enable  = enable_d;
		res.serial_clock = clock_d;
		res.io_out       = drive_d & level_d;
		res.io_drive     = drive_d;
		res.done_res     = done_d;
		res.read_byte    = (done_d && active_op_q == OP_READ_BYTE[1:0]) ? data_q : 8'h00;
		res.fields       = (done_d && active_op_q == OP_BURST_READ[1:0]) ? fields_q : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			active_op_q  <= '0;
			half_phase_q <= 1'b0;
			bit_index_q  <= '0;
			byte_index_q <= '0;
			enable_q     <= 1'b0;
			clock_q      <= 1'b0;
			level_q      <= 1'b0;
			drive_q      <= 1'b0;
		end else if (adv) begin
			busy_q       <= busy_d;
			active_op_q  <= active_op_d;
			half_phase_q <= half_phase_d;
			bit_index_q  <= bit_index_d;
			byte_index_q <= byte_index_d;
			enable_q     <= enable_d;
			clock_q      <= clock_d;
			level_q      <= level_d;
			drive_q      <= drive_d;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			shift_q   <= shift_d;
			command_q <= command_d;
			data_q    <= data_d;
			fields_q  <= fields_d;
		end
	end

endmodule

[src/rtc_three_wire_master.sv]
// Master for a three-wire serial link to a real-time-clock chip.
// Input stream: each beat is a command (write byte, read byte, burst read,
// burst write) or a tick; a tick is one half bit period of the serial link.
// A command seen while a transfer runs is dropped; a tick while idle does
// nothing. Output stream: exactly one beat per input beat, carrying the
// enable, clock and data line levels after that beat, the drive flag, and
// on the tick that ends a transfer tlast high with the read byte or the
// burst-read date and time (zeros otherwise).
// Pipeline: an input beat is registered, its result is computed from that
// register and the transfer state and is then held in the result register.
// Throughput: one beat per cycle while the output does not stall; the state
// update for a beat is a single pass of shallow logic between the input
// and result registers.
// Reset: all control state clears, the link is idle, enable and clock low.
// When the output stalls, the input register holds one pending beat and
// tready falls only once both registers are full.
module rtc_three_wire_master (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// address[7:0], write_data[15:8], set_day[23:16], set_month[31:24],
	// set_year[39:32], set_hour[47:40], set_minute[55:48], set_second[63:56],
	// io_in[64], zero fill above
	input  logic [71:0] s_axis_tdata,
	// operation[2:0]
	input  logic [2:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// chip_enable[0], serial_clock[1], io_out[2], io_drive[3], read_byte[11:4],
	// day[19:12], month[27:20], year[35:28], hour[43:36], minute[51:44],
	// second[59:52], zero fill above
	output logic [63:0] m_axis_tdata,
	// done_res
	output logic        m_axis_tlast
);
	import rtcw_pkg::*;

	logic    valid_s1;
	item_t   item_s1;
	logic    m_valid_q;
	result_t result_q;
	result_t res;
	logic    adv;
	logic    take;

	assign adv           = valid_s1 && (!m_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv;
	assign take          = s_axis_tvalid && s_axis_tready;

	rtcw_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.item   (item_s1),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (s_axis_tready)
				valid_s1 <= s_axis_tvalid;
			if (adv)
				m_valid_q <= 1'b1;
			else if (m_axis_tready)
				m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.operation     <= s_axis_tuser;
			item_s1.address       <= s_axis_tdata[7:0];
			item_s1.write_data    <= s_axis_tdata[15:8];
			item_s1.set_fields[0] <= s_axis_tdata[23:16];
			item_s1.set_fields[1] <= s_axis_tdata[31:24];
			item_s1.set_fields[2] <= s_axis_tdata[39:32];
			item_s1.set_fields[3] <= s_axis_tdata[47:40];
			item_s1.set_fields[4] <= s_axis_tdata[55:48];
			item_s1.set_fields[5] <= s_axis_tdata[63:56];
			item_s1.io_in         <= s_axis_tdata[64];
		end
		if (adv)
			result_q <= res;
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tlast  = result_q.done_res;
	assign m_axis_tdata  = {4'h0,
		result_q.fields[5], result_q.fields[4], result_q.fields[3],
		result_q.fields[2], result_q.fields[1], result_q.fields[0],
		result_q.read_byte, result_q.io_drive, result_q.io_out,
		result_q.serial_clock, result_q.chip_enable};

endmodule
